@@ hw/rtl/grc_pkg.sv @@
// shared types, constants and tables of the grid ray caster
package grc_pkg;

    // map and stepping
    localparam int MAP_SIDE     = 16;
    localparam int MAX_STEPS    = 16;
    localparam int ANGLE_BITS   = 12;
    localparam int CELL_UNITS   = 64;
    localparam int CELL_BITS    = $clog2(CELL_UNITS);
    localparam int QSHIFT       = 8;
    localparam int MAP_BITS     = $clog2(MAP_SIDE);
    localparam int MAP_DEPTH    = MAP_SIDE * MAP_SIDE;
    localparam int MAP_AW       = 2 * MAP_BITS;
    localparam int CELL_SHIFT   = QSHIFT + CELL_BITS;
    localparam int LIM_BIT      = CELL_SHIFT + MAP_BITS;
    localparam int COORD_W      = MAP_BITS + CELL_BITS;
    localparam int DX_W         = COORD_W + 1;
    localparam int STEP_W       = $clog2(MAX_STEPS + 1);

    // cordic
    localparam int CORDIC_STEPS = 14;
    localparam int CSTEP_W      = $clog2(CORDIC_STEPS);
    localparam int CORD_W       = 23;
    localparam int Z_W          = 17;
    localparam int TRIG_W       = 22;
    localparam int CORDIC_ONE   = 1 << 20;

    // datapath widths
    localparam int POS_IN_W     = 10;
    localparam int MUL_A_W      = 20;
    localparam int PROD_W       = MUL_A_W + TRIG_W;
    localparam int POS_W        = 44;
    localparam int SQ_W         = 2 * COORD_W + 2;
    localparam int RT_W         = SQ_W / 2;
    localparam int CFG_W        = 10;
    localparam int STEP_Q       = CELL_UNITS << QSHIFT;

    // register map
    localparam logic REG_PROJ  = 1'b0;
    localparam logic REG_PLANE = 1'b1;
    localparam logic [CFG_W-1:0] PROJ_RESET  = 10'd255;
    localparam logic [CFG_W-1:0] PLANE_RESET = 10'd200;

    // item actions
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CAST  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  cell_x;
        logic [3:0]  cell_y;
        logic        cell_wall;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic [11:0] ray_angle;
    } t_in_item;

    typedef struct packed {
        logic               hit_found;
        logic               hit_vertical;
        logic signed [15:0] hit_x;
        logic signed [15:0] hit_y;
        logic [15:0]        distance;
        logic [9:0]         line_height;
    } t_out_item;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] num;
        logic signed [TRIG_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CORD,
        S_DIR,
        S_SEL,
        S_PSET,
        S_MUL1,
        S_DIV1,
        S_MUL2,
        S_DIV2,
        S_MCHK,
        S_MRD,
        S_SQ1,
        S_SQ2,
        S_PEND,
        S_CMP,
        S_SQRT,
        S_HGT,
        S_OUT
    } t_state;

    // arctangent of 2^-i, 65536 per turn
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [CSTEP_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            4'd0:    v = 17'sd8192;
            4'd1:    v = 17'sd4836;
            4'd2:    v = 17'sd2555;
            4'd3:    v = 17'sd1297;
            4'd4:    v = 17'sd651;
            4'd5:    v = 17'sd326;
            4'd6:    v = 17'sd163;
            4'd7:    v = 17'sd81;
            4'd8:    v = 17'sd41;
            4'd9:    v = 17'sd20;
            4'd10:   v = 17'sd10;
            4'd11:   v = 17'sd5;
            4'd12:   v = 17'sd3;
            4'd13:   v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/grc_ram.sv @@
// generic single-port ram with registered read
module grc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ hw/rtl/grc_div.sv @@
// shared restoring divider, signed, truncating, one quotient bit per cycle
module grc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  grc_pkg::t_div_req i_req,
    output grc_pkg::t_div_rsp o_rsp
);
    localparam int MAG_W = grc_pkg::PROD_W - 1;
    localparam int DM_W  = grc_pkg::TRIG_W - 1;
    localparam int CNT_W = $clog2(MAG_W);

    logic [MAG_W-1:0] r_dq;
    logic [DM_W:0]    r_rem;
    logic [DM_W-1:0]  r_dm;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic signed [grc_pkg::PROD_W-1:0] num_abs;
    logic signed [grc_pkg::TRIG_W-1:0] den_abs;
    logic [DM_W:0]   sh;
    logic [DM_W+1:0] diff;
    logic            ge;

    always_comb begin
        num_abs = i_req.num[grc_pkg::PROD_W-1] ? -i_req.num : i_req.num;
        den_abs = i_req.den[grc_pkg::TRIG_W-1] ? -i_req.den : i_req.den;
        sh      = {r_rem[DM_W-1:0], r_dq[MAG_W-1]};
        diff    = {1'b0, sh} - {2'b00, r_dm};
        ge      = ~diff[DM_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dq  <= num_abs[MAG_W-1:0];
            r_dm  <= den_abs[DM_W-1:0];
            r_rem <= '0;
            r_neg <= i_req.num[grc_pkg::PROD_W-1] ^ i_req.den[grc_pkg::TRIG_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[DM_W:0] : sh;
            r_dq  <= {r_dq[MAG_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
endmodule

@@ hw/rtl/grid_ray_caster.sv @@
// grid ray caster top level: map store, cordic, grid stepping, distance and height
// a map write is stored as it is taken; a cast runs the cordic and setup, then per pass
//   two divisions plus the stepping and hit distance, then the square root and one
//   division for the line height
// throughput: one cast at a time; the result sits in an output register, so the next
//   item is taken while it waits
// reset: control state clears at once, then a sweep clears every wall map cell, no item taken
module grid_ray_caster (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  grc_pkg::t_in_item    i_in,
    output logic                 o_valid,
    input  logic                 i_ready,
    output grc_pkg::t_out_item   o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    localparam int PW  = grc_pkg::POS_W;
    localparam int AW  = grc_pkg::MUL_A_W;
    localparam int TW  = grc_pkg::TRIG_W;
    localparam int CW  = grc_pkg::CORD_W;
    localparam int SW  = grc_pkg::SQ_W;
    localparam int QS  = grc_pkg::QSHIFT;
    localparam int DW  = grc_pkg::DX_W;

    // configuration registers
    logic [grc_pkg::CFG_W-1:0] r_proj;
    logic [grc_pkg::CFG_W-1:0] r_plane;

    // sequencer
    grc_pkg::t_state r_state;
    grc_pkg::t_state n_state;

    // map clearing sweep
    logic                       r_clr_busy;
    logic [grc_pkg::MAP_AW-1:0] r_clr_addr;

    // item registers
    logic [grc_pkg::POS_IN_W-1:0] r_px;
    logic [grc_pkg::POS_IN_W-1:0] r_py;

    // cordic
    logic signed [CW-1:0]            r_cx;
    logic signed [CW-1:0]            r_cy;
    logic signed [grc_pkg::Z_W-1:0]  r_z;
    logic [1:0]                      r_quad;
    logic                            r_rem0;
    logic [grc_pkg::CSTEP_W-1:0]     r_cnt;
    logic signed [TW-1:0]            r_c;
    logic signed [TW-1:0]            r_s;

    // pass state: major axis is the one whose grid lines are crossed
    logic                            r_pv;
    logic signed [PW-1:0]            r_maj;
    logic signed [PW-1:0]            r_min;
    logic signed [PW-1:0]            r_smaj;
    logic signed [PW-1:0]            r_smin;
    logic signed [AW-1:0]            r_diff;
    logic [grc_pkg::STEP_W-1:0]      r_k;
    logic signed [grc_pkg::PROD_W-1:0] r_prod;
    logic                            r_go;
    logic                            n_go;

    // hits
    logic [grc_pkg::COORD_W-1:0] r_tx, r_ty;
    logic [SW-1:0]               r_acc;
    logic                        r_hf, r_vf;
    logic [grc_pkg::COORD_W-1:0] r_hx, r_hy, r_vx, r_vy;
    logic [SW-1:0]               r_dh, r_dv;
    logic                        r_usev;
    logic                        r_found;

    // root and height
    logic [SW-1:0]               r_sv, r_sr, r_sbit;
    logic [grc_pkg::CFG_W-1:0]   r_lh;

    // output register
    logic                  r_ovalid;
    grc_pkg::t_out_item    r_out;

    // shared units
    grc_pkg::t_div_req div_req;
    grc_pkg::t_div_rsp div_rsp;
    logic signed [AW-1:0]              mul_a;
    logic signed [TW-1:0]              mul_b;
    logic signed [grc_pkg::PROD_W-1:0] prod;

    // map port
    logic                       ram_we;
    logic [grc_pkg::MAP_AW-1:0] ram_addr;
    logic                       ram_wdata;
    logic                       ram_rdata;

    // combinational helpers
    logic                  in_acc;
    logic                  cfg_wr;
    logic signed [CW-1:0]  cx_sh, cy_sh;
    logic signed [TW-1:0]  cm, sm;
    logic signed [TW-1:0]  cb, den;
    logic                  sdir;
    logic [grc_pkg::POS_IN_W-1:0] pb, po;
    logic signed [AW-1:0]  rmaj, qmaj;
    logic signed [PW-1:0]  cur_x, cur_y;
    logic                  inb;
    logic                  last_step;
    logic [SW-1:0]         sq_t, n_sv, n_sr;
    logic                  sq_ge;
    logic signed [DW-1:0]  dx, dy;
    logic [15:0]           a16;
    logic                  cell_ok;
    logic [SW-1:0]         dsq;

    assign in_acc = i_valid & o_ready;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    // register read
    always_comb begin
        case (paddr[2])
            grc_pkg::REG_PROJ:  prdata = 32'(r_proj);
            grc_pkg::REG_PLANE: prdata = 32'(r_plane);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj  <= grc_pkg::PROJ_RESET;
            r_plane <= grc_pkg::PLANE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                grc_pkg::REG_PROJ:  r_proj  <= pwdata[grc_pkg::CFG_W-1:0];
                grc_pkg::REG_PLANE: r_plane <= pwdata[grc_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // cordic micro-rotation, angle as 16 bits per turn
    always_comb begin
        a16   = 16'(i_in.ray_angle[grc_pkg::ANGLE_BITS-1:0]) << (16 - grc_pkg::ANGLE_BITS);
        cx_sh = r_cy >>> r_cnt;
        cy_sh = r_cx >>> r_cnt;
        cm    = r_cx[CW-1] ? TW'(-r_cx) : TW'(r_cx);
        sm    = r_cy[CW-1] ? TW'(-r_cy) : TW'(r_cy);
        if (cm == '0) cm = TW'(1);
        if (sm == '0) sm = TW'(1);
        if (r_rem0) begin
            cm = TW'(grc_pkg::CORDIC_ONE);
            sm = '0;
        end
    end

    // pass geometry: first grid line crossed along the major axis
    always_comb begin
        cb    = r_pv ? r_s : r_c;
        den   = r_pv ? r_c : r_s;
        sdir  = den[TW-1];
        pb    = r_pv ? r_px : r_py;
        po    = r_pv ? r_py : r_px;
        qmaj  = AW'(pb) << QS;
        if (sdir) begin
            rmaj = (AW'(pb[grc_pkg::POS_IN_W-1:grc_pkg::CELL_BITS]) << grc_pkg::CELL_SHIFT)
                   - AW'(1);
        end else begin
            rmaj = (AW'(pb[grc_pkg::POS_IN_W-1:grc_pkg::CELL_BITS]) + AW'(1))
                   << grc_pkg::CELL_SHIFT;
        end
        cur_x     = r_pv ? r_maj : r_min;
        cur_y     = r_pv ? r_min : r_maj;
        inb       = (cur_x[PW-1:grc_pkg::LIM_BIT] == '0) && (cur_y[PW-1:grc_pkg::LIM_BIT] == '0);
        last_step = (r_k == grc_pkg::STEP_W'(grc_pkg::MAX_STEPS - 1));
        dx        = DW'(r_tx) - DW'(r_px);
        dy        = DW'(r_ty) - DW'(r_py);
        dsq       = r_acc + prod[SW-1:0];
        // one bit of the square root per cycle
        sq_t      = r_sr + r_sbit;
        sq_ge     = (r_sv >= sq_t);
        n_sv      = sq_ge ? r_sv - sq_t : r_sv;
        n_sr      = sq_ge ? (r_sr >> 1) + r_sbit : r_sr >> 1;
        cell_ok   = (32'(i_in.cell_x) < 32'(grc_pkg::MAP_SIDE)) &&
                    (32'(i_in.cell_y) < 32'(grc_pkg::MAP_SIDE));
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            grc_pkg::S_IDLE: begin
                if (in_acc && i_in.action == grc_pkg::ACT_CAST) n_state = grc_pkg::S_CORD;
            end
            grc_pkg::S_CORD: begin
                if (r_cnt == grc_pkg::CSTEP_W'(grc_pkg::CORDIC_STEPS - 1)) begin
                    n_state = grc_pkg::S_DIR;
                end
            end
            grc_pkg::S_DIR:  n_state = grc_pkg::S_SEL;
            grc_pkg::S_SEL: begin
                if (r_s != '0 || r_c != '0) n_state = grc_pkg::S_PSET;
                else                        n_state = grc_pkg::S_CMP;
            end
            grc_pkg::S_PSET: n_state = grc_pkg::S_MUL1;
            grc_pkg::S_MUL1: n_state = grc_pkg::S_DIV1;
            grc_pkg::S_DIV1: if (div_rsp.done) n_state = grc_pkg::S_MUL2;
            grc_pkg::S_MUL2: n_state = grc_pkg::S_DIV2;
            grc_pkg::S_DIV2: if (div_rsp.done) n_state = grc_pkg::S_MCHK;
            grc_pkg::S_MCHK: begin
                if (inb)            n_state = grc_pkg::S_MRD;
                else if (last_step) n_state = grc_pkg::S_PEND;
            end
            grc_pkg::S_MRD: begin
                if (ram_rdata)      n_state = grc_pkg::S_SQ1;
                else if (last_step) n_state = grc_pkg::S_PEND;
                else                n_state = grc_pkg::S_MCHK;
            end
            grc_pkg::S_SQ1:  n_state = grc_pkg::S_SQ2;
            grc_pkg::S_SQ2:  n_state = grc_pkg::S_PEND;
            grc_pkg::S_PEND: begin
                if (!r_pv && r_c != '0) n_state = grc_pkg::S_PSET;
                else                    n_state = grc_pkg::S_CMP;
            end
            grc_pkg::S_CMP: begin
                if (r_hf || r_vf) n_state = grc_pkg::S_SQRT;
                else              n_state = grc_pkg::S_OUT;
            end
            grc_pkg::S_SQRT: begin
                if (r_sbit == SW'(1)) begin
                    if (n_sr == '0) n_state = grc_pkg::S_OUT;
                    else            n_state = grc_pkg::S_HGT;
                end
            end
            grc_pkg::S_HGT:  if (div_rsp.done) n_state = grc_pkg::S_OUT;
            grc_pkg::S_OUT:  if (!r_ovalid || i_ready) n_state = grc_pkg::S_IDLE;
            default:         n_state = grc_pkg::S_IDLE;
        endcase
    end

    // control outputs and shared unit operands
    always_comb begin
        o_ready   = (r_state == grc_pkg::S_IDLE) && !r_clr_busy;
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = {cur_y[grc_pkg::LIM_BIT-1:grc_pkg::CELL_SHIFT],
                     cur_x[grc_pkg::LIM_BIT-1:grc_pkg::CELL_SHIFT]};
        if (r_clr_busy) begin
            ram_we   = 1'b1;
            ram_addr = r_clr_addr;
        end else if (in_acc && i_in.action == grc_pkg::ACT_WRITE && cell_ok) begin
            ram_we    = 1'b1;
            ram_wdata = i_in.cell_wall;
            ram_addr  = {grc_pkg::MAP_BITS'(i_in.cell_y), grc_pkg::MAP_BITS'(i_in.cell_x)};
        end

        case (r_state)
            grc_pkg::S_MUL1: begin
                mul_a = r_diff;
                mul_b = cb;
            end
            grc_pkg::S_MUL2: begin
                mul_a = r_smaj[AW-1:0];
                mul_b = cb;
            end
            grc_pkg::S_SQ1: begin
                mul_a = AW'(dx);
                mul_b = TW'(dx);
            end
            grc_pkg::S_SQ2: begin
                mul_a = AW'(dy);
                mul_b = TW'(dy);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        div_req.start = r_go;
        div_req.num   = r_prod;
        div_req.den   = (r_state == grc_pkg::S_HGT) ? TW'(r_sr[grc_pkg::RT_W-1:0]) : den;

        n_go = (n_state != r_state) &&
               (n_state == grc_pkg::S_DIV1 || n_state == grc_pkg::S_DIV2 ||
                n_state == grc_pkg::S_HGT);
    end

    assign prod = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= grc_pkg::S_IDLE;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
            r_go       <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == grc_pkg::MAP_AW'(grc_pkg::MAP_DEPTH - 1)) r_clr_busy <= 1'b0;
            end
            if (r_state == grc_pkg::S_OUT && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (i_ready)                                      r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            grc_pkg::S_IDLE: begin
                r_px   <= i_in.pos_x;
                r_py   <= i_in.pos_y;
                r_cx   <= CW'(grc_pkg::CORDIC_ONE);
                r_cy   <= '0;
                r_z    <= grc_pkg::Z_W'(a16[13:0]);
                r_quad <= a16[15:14];
                r_rem0 <= (a16[13:0] == '0);
                r_cnt  <= '0;
                r_hf   <= 1'b0;
                r_vf   <= 1'b0;
                r_pv   <= 1'b0;
            end
            grc_pkg::S_CORD: begin
                r_cnt <= r_cnt + 1'b1;
                if (!r_z[grc_pkg::Z_W-1]) begin
                    r_cx <= r_cx - cx_sh;
                    r_cy <= r_cy + cy_sh;
                    r_z  <= r_z - grc_pkg::atan_q16(r_cnt);
                end else begin
                    r_cx <= r_cx + cx_sh;
                    r_cy <= r_cy - cy_sh;
                    r_z  <= r_z + grc_pkg::atan_q16(r_cnt);
                end
            end
            grc_pkg::S_DIR: begin
                // quadrant rotation of the first-quadrant magnitudes
                case (r_quad)
                    2'd0:    begin r_c <= cm;  r_s <= sm;  end
                    2'd1:    begin r_c <= -sm; r_s <= cm;  end
                    2'd2:    begin r_c <= -cm; r_s <= -sm; end
                    default: begin r_c <= sm;  r_s <= -cm; end
                endcase
            end
            grc_pkg::S_SEL: begin
                // ray along x has no horizontal crossings
                r_pv <= (r_s == '0);
            end
            grc_pkg::S_PSET: begin
                r_maj  <= PW'(rmaj);
                r_diff <= rmaj - qmaj;
                r_smaj <= sdir ? -PW'(grc_pkg::STEP_Q) : PW'(grc_pkg::STEP_Q);
                r_k    <= '0;
            end
            grc_pkg::S_MUL1: r_prod <= prod;
            grc_pkg::S_DIV1: if (div_rsp.done) r_min <= (PW'(po) <<< QS) + PW'(div_rsp.quo);
            grc_pkg::S_MUL2: r_prod <= prod;
            grc_pkg::S_DIV2: if (div_rsp.done) r_smin <= PW'(div_rsp.quo);
            grc_pkg::S_MCHK: begin
                if (!inb) begin
                    r_maj <= r_maj + r_smaj;
                    r_min <= r_min + r_smin;
                    r_k   <= r_k + 1'b1;
                end
            end
            grc_pkg::S_MRD: begin
                if (ram_rdata) begin
                    r_tx <= cur_x[grc_pkg::LIM_BIT-1:QS];
                    r_ty <= cur_y[grc_pkg::LIM_BIT-1:QS];
                end else begin
                    r_maj <= r_maj + r_smaj;
                    r_min <= r_min + r_smin;
                    r_k   <= r_k + 1'b1;
                end
            end
            grc_pkg::S_SQ1: r_acc <= prod[SW-1:0];
            grc_pkg::S_SQ2: begin
                if (r_pv) begin
                    r_vf <= 1'b1;
                    r_vx <= r_tx;
                    r_vy <= r_ty;
                    r_dv <= dsq;
                end else begin
                    r_hf <= 1'b1;
                    r_hx <= r_tx;
                    r_hy <= r_ty;
                    r_dh <= dsq;
                end
            end
            grc_pkg::S_PEND: r_pv <= 1'b1;
            grc_pkg::S_CMP: begin
                // tie keeps the horizontal hit
                r_found <= r_hf | r_vf;
                r_usev  <= r_vf && (!r_hf || r_dv < r_dh);
                r_sv    <= (r_vf && (!r_hf || r_dv < r_dh)) ? r_dv : r_dh;
                r_sr    <= '0;
                r_sbit  <= SW'(1) << (SW - 2);
                r_lh    <= '0;
            end
            grc_pkg::S_SQRT: begin
                r_sv   <= n_sv;
                r_sr   <= n_sr;
                r_sbit <= r_sbit >> 2;
                r_prod <= grc_pkg::PROD_W'(r_proj) << grc_pkg::CELL_BITS;
                // zero distance keeps the full plane height
                r_lh   <= r_plane;
            end
            grc_pkg::S_HGT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quo > grc_pkg::PROD_W'(r_plane)) r_lh <= r_plane;
                    else r_lh <= div_rsp.quo[grc_pkg::CFG_W-1:0];
                end
            end
            grc_pkg::S_OUT: begin
                if (!r_ovalid || i_ready) begin
                    r_out.hit_found    <= r_found;
                    r_out.hit_vertical <= r_found & r_usev;
                    r_out.hit_x        <= !r_found ? '0 : r_usev ? 16'(r_vx) : 16'(r_hx);
                    r_out.hit_y        <= !r_found ? '0 : r_usev ? 16'(r_vy) : 16'(r_hy);
                    r_out.distance     <= r_found ? 16'(r_sr) : 16'hFFFF;
                    r_out.line_height  <= r_lh;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    grc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    grc_ram #(
        .WIDTH (1),
        .DEPTH (grc_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // a finished result lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grc_pkg::S_OUT && n_state == grc_pkg::S_IDLE) |=> o_valid)
        else $error("result not registered");

    // divider answers only where the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == grc_pkg::S_DIV1 || r_state == grc_pkg::S_DIV2 ||
                          r_state == grc_pkg::S_HGT))
        else $error("divider done outside a wait state");

    // no item taken while the map is being cleared
    a_clr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !o_ready)
        else $error("item taken during map clear");

    // stepping stays within the step limit
    a_step_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == grc_pkg::S_MCHK || r_state == grc_pkg::S_MRD) |->
        (r_k < grc_pkg::STEP_W'(grc_pkg::MAX_STEPS)))
        else $error("step counter past limit");
endmodule

@@ tb/grid_ray_caster_tb.sv @@
// testbench of the grid ray caster: random map writes and ray casts checked against a predictor
`timescale 1ns / 1ps

module grid_ray_caster_tb;
    localparam int IN_W = $bits(grc_pkg::t_in_item);
    localparam int PROJ_SET [5]  = '{255, 1, 1023, 1023, 300};
    localparam int PLANE_SET [5] = '{200, 1, 1023, 1, 600};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    grc_pkg::t_in_item    i_in;
    logic                 o_valid;
    logic                 i_ready;
    grc_pkg::t_out_item   o_out;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    grid_ray_caster i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the block state
    bit          wall_copy [grc_pkg::MAP_DEPTH];
    longint      proj_dist;
    longint      plane_hgt;

    grc_pkg::t_in_item    pending_items [$];
    grc_pkg::t_out_item   expected_hits [$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;

    // clock, 8 ns period
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint atan_tab(int i);
        longint t [14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
        return t[i];
    endfunction

    // ray direction: cordic on the remainder below a quarter turn, then quadrant mapping
    function automatic void ray_dir(input logic [15:0] a16, output longint cv,
                                    output longint sv);
        longint x, y, z, dx, dy, cm, sm;
        x = grc_pkg::CORDIC_ONE;
        y = 0;
        z = a16[13:0];
        cm = grc_pkg::CORDIC_ONE;
        sm = 0;
        if (a16[13:0] != 0) begin
            for (int i = 0; i < grc_pkg::CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= atan_tab(i);
                end else begin
                    x += dx; y -= dy; z += atan_tab(i);
                end
            end
            cm = (x < 0) ? -x : x;
            sm = (y < 0) ? -y : y;
            if (cm == 0) cm = 1;
            if (sm == 0) sm = 1;
        end
        case (a16[15:14])
            2'd0:    begin cv = cm;  sv = sm;  end
            2'd1:    begin cv = -sm; sv = cm;  end
            2'd2:    begin cv = -cm; sv = -sm; end
            default: begin cv = sm;  sv = -cm; end
        endcase
    endfunction

    // step along one family of grid lines until a wall cell or the step limit
    function automatic bit grid_march(longint x, longint y, longint sx, longint sy,
                                      output longint hx, output longint hy);
        longint lim;
        lim = longint'(grc_pkg::MAP_SIDE) * grc_pkg::CELL_UNITS * 256;
        hx = 0;
        hy = 0;
        for (int k = 0; k < grc_pkg::MAX_STEPS; k++) begin
            if (x >= 0 && y >= 0 && x < lim && y < lim) begin
                if (wall_copy[(y >>> grc_pkg::CELL_SHIFT) * grc_pkg::MAP_SIDE
                              + (x >>> grc_pkg::CELL_SHIFT)]) begin
                    hx = x >>> grc_pkg::QSHIFT;
                    hy = y >>> grc_pkg::QSHIFT;
                    return 1'b1;
                end
            end
            x += sx;
            y += sy;
        end
        return 1'b0;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // expected result of one cast
    function automatic grc_pkg::t_out_item cast_ray(grc_pkg::t_in_item it);
        longint px, py, qx, qy, c, s, base, rx, ry, sx, sy;
        longint hx, hy, vx, vy, dh, dv, d, lh, x, y;
        bit hf, vf, use_v;
        grc_pkg::t_out_item r;
        px = it.pos_x;
        py = it.pos_y;
        qx = px << grc_pkg::QSHIFT;
        qy = py << grc_pkg::QSHIFT;
        ray_dir({it.ray_angle, 4'b0}, c, s);
        hx = 0; hy = 0; vx = 0; vy = 0;
        hf = 1'b0;
        vf = 1'b0;
        // horizontal lines, skipped for rays along x
        if (s != 0) begin
            base = (py >>> 6) << 6;
            if (s > 0) begin
                ry = (base + grc_pkg::CELL_UNITS) << grc_pkg::QSHIFT; sy = grc_pkg::STEP_Q;
            end else begin
                ry = (base << grc_pkg::QSHIFT) - 1; sy = -grc_pkg::STEP_Q;
            end
            rx = qx + (ry - qy) * c / s;
            hf = grid_march(rx, ry, sy * c / s, sy, hx, hy);
        end
        // vertical lines, skipped for rays along y
        if (c != 0) begin
            base = (px >>> 6) << 6;
            if (c > 0) begin
                rx = (base + grc_pkg::CELL_UNITS) << grc_pkg::QSHIFT; sx = grc_pkg::STEP_Q;
            end else begin
                rx = (base << grc_pkg::QSHIFT) - 1; sx = -grc_pkg::STEP_Q;
            end
            ry = qy + (rx - qx) * s / c;
            vf = grid_march(rx, ry, sx, sx * s / c, vx, vy);
        end
        dh = (hx - px) * (hx - px) + (hy - py) * (hy - py);
        dv = (vx - px) * (vx - px) + (vy - py) * (vy - py);
        r = '0;
        if (!hf && !vf) begin
            r.distance = 16'hFFFF;
            return r;
        end
        // tie goes to the horizontal hit
        use_v = vf && (!hf || dv < dh);
        x = use_v ? vx : hx;
        y = use_v ? vy : hy;
        d = int_sqrt(use_v ? dv : dh);
        if (d > 65535) d = 65535;
        lh = (d == 0) ? plane_hgt : proj_dist * grc_pkg::CELL_UNITS / d;
        if (lh > plane_hgt) lh = plane_hgt;
        r.hit_found    = 1'b1;
        r.hit_vertical = use_v;
        r.hit_x        = clamp16(x);
        r.hit_y        = clamp16(y);
        r.distance     = d[15:0];
        r.line_height  = lh[9:0];
        return r;
    endfunction

    // driver: presents pending items, records the expectation when one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                if (i_in.action == grc_pkg::ACT_WRITE)
                    wall_copy[i_in.cell_y * grc_pkg::MAP_SIDE + i_in.cell_x] = i_in.cell_wall;
                else
                    expected_hits.push_back(cast_ray(i_in));
            end
            // hold a waiting item, else maybe present the next one
            if (!(i_valid && !o_ready)) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_in    <= pending_items.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each taken result against the oldest expectation
    always @(posedge i_clk) begin
        grc_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item: %p", o_out);
                end else begin
                    want = expected_hits.pop_front();
                    if (o_out.hit_found !== want.hit_found
                        || o_out.hit_vertical !== want.hit_vertical
                        || o_out.hit_x !== want.hit_x || o_out.hit_y !== want.hit_y
                        || o_out.distance !== want.distance
                        || o_out.line_height !== want.line_height) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, o_out);
                    end
                end
            end
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // register write over the config port, setup then access
    task automatic reg_write(input logic [2:0] addr, input logic [9:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= {22'b0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd4 * grc_pkg::REG_PLANE) plane_hgt = val;
        else proj_dist = val;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_valid || expected_hits.size() != 0)
            @(posedge i_clk);
        // a trailing map write may still be in flight
        repeat (400) @(posedge i_clk);
    endtask

    function automatic grc_pkg::t_in_item cast_item(int px, int py, int ang);
        grc_pkg::t_in_item it;
        it = grc_pkg::t_in_item'(IN_W'({$urandom, $urandom}));
        it.action    = grc_pkg::ACT_CAST;
        it.pos_x     = 10'(px);
        it.pos_y     = 10'(py);
        it.ray_angle = 12'(ang);
        return it;
    endfunction

    function automatic grc_pkg::t_in_item wall_item(int cx, int cy, bit w);
        grc_pkg::t_in_item it;
        it = grc_pkg::t_in_item'(IN_W'({$urandom, $urandom}));
        it.action    = grc_pkg::ACT_WRITE;
        it.cell_x    = 4'(cx);
        it.cell_y    = 4'(cy);
        it.cell_wall = w;
        return it;
    endfunction

    // mostly casts over a map that keeps changing, axis angles now and then
    task automatic queue_random(int n);
        int ang;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 30) begin
                pending_items.push_back(wall_item($urandom_range(0, 15), $urandom_range(0, 15),
                                                  $urandom_range(0, 99) < 40));
            end else begin
                ang = ($urandom_range(0, 9) == 0) ? 1024 * $urandom_range(0, 3)
                                                  : $urandom_range(0, 4095);
                pending_items.push_back(cast_item($urandom_range(0, 1023),
                                                  $urandom_range(0, 1023), ang));
            end
        end
    endtask

    initial begin
        mismatches     = 0;
        proj_dist      = grc_pkg::PROJ_RESET;
        plane_hgt      = grc_pkg::PLANE_RESET;
        send_idle_pct  = 29;
        recv_stall_pct = 58;
        i_rst_n <= 1'b0;
        i_in    <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty map gives no hit, then walls on every third cell of two map edges and extremes
        pending_items.push_back(cast_item(512, 512, 0));
        pending_items.push_back(cast_item(0, 0, 4095));
        for (int i = 0; i < 16; i += 3) begin
            pending_items.push_back(wall_item(i, 0, 1'b1));
            pending_items.push_back(wall_item(15, i, 1'b1));
        end
        pending_items.push_back(wall_item(15, 15, 1'b1));
        pending_items.push_back(wall_item(0, 15, 1'b1));
        pending_items.push_back(wall_item(0, 15, 1'b0));
        for (int a = 0; a < 4; a++)
            pending_items.push_back(cast_item(1023, 1023, a * 1024));
        pending_items.push_back(cast_item(0, 0, 512));
        pending_items.push_back(cast_item(32, 32, 3584));
        pending_items.push_back(cast_item(960, 64, 1));
        pending_items.push_back(cast_item(64, 64, 2048));

        for (int p = 0; p < 5; p++) begin
            wait_idle();
            if (p == 2) begin
                send_idle_pct  <= 58;
                recv_stall_pct <= 29;
            end else if (p == 4) begin
                send_idle_pct  <= 0;
                recv_stall_pct <= 0;
            end
            reg_write(3'd4 * grc_pkg::REG_PROJ, 10'(PROJ_SET[p]));
            reg_write(3'd4 * grc_pkg::REG_PLANE, 10'(PLANE_SET[p]));
            queue_random(260);
        end

        wait_idle();
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/grc_pkg.sv
hw/rtl/grc_ram.sv
hw/rtl/grc_div.sv
hw/rtl/grid_ray_caster.sv
tb/grid_ray_caster_tb.sv
